// ----- hw/rtl/cfc_pkg.sv -----
// cfc_pkg: shared types, register indexes and the crc-16 byte fold
// used by the frame checker modules; no dependencies
`default_nettype none

package cfc_pkg;

   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_CODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESPONSE_LENGTH = 2'd2;

   localparam logic [7:0]  RST_DEVICE_ADDRESS  = 8'd128;
   localparam logic [7:0]  RST_COMMAND_CODE    = 8'd0;
   localparam logic [7:0]  RST_RESPONSE_LENGTH = 8'd2;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] command_code;
      logic [7:0] response_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic       is_check;
      logic       crc_ok;
      logic       last;
   } result_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crc16_response_frame_checker_unit.sv -----
// crc16_response_frame_checker_unit: top level, input register, frame engine
// and result register; depends on cfc_pkg, cfc_csr_regs, cfc_frame_engine
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_byte_value, req_start_req
//   rsp       out        rsp_valid/rsp_ready  data_byte, byte_index, is_check, crc_ok, last
//   csr       in         csr_write_en         csr_index, csr_wdata
//
// one transaction per cycle sustained unless stalled; rsp_valid is the result register flag
// the crc update, seed and frame compare run in the single engine step between the
// input register and the result register
// a crc high byte gives no result and passes through without waiting on rsp_ready
// rsp_ready low stalls the input register only when a result is waiting and the
// held byte makes another one
// synchronous reset clears valid flags, frame state and the registers to defaults
`default_nettype none

module crc16_response_frame_checker_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_byte_value,
   input  wire logic                           req_start_req,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [7:0]                          rsp_data_byte,
   output logic [7:0]                          rsp_byte_index,
   output logic                                rsp_is_check,
   output logic                                rsp_crc_ok,
   output logic                                rsp_last,
   input  wire logic                           csr_write_en,
   input  wire logic [cfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [7:0]                     csr_wdata
);
   import cfc_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       has_result;
   result_type result;
   logic       advance;

   cfc_csr_regs u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   cfc_frame_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_en    (advance),
      .byte_value (in_byte_ff),
      .start_req  (in_start_ff),
      .has_result (has_result),
      .result     (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready || !has_result);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_byte_value;
         in_start_ff <= req_start_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_data_byte  = out_ff.data_byte;
   assign rsp_byte_index = out_ff.byte_index;
   assign rsp_is_check   = out_ff.is_check;
   assign rsp_crc_ok     = out_ff.crc_ok;
   assign rsp_last       = out_ff.last;

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !(advance && has_result))
      else $error("result register overwritten while stalled");

   // a held input byte blocks the next transaction
   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_ready)
      else $error("input accepted while held byte not consumed");

   // check result carries zero data and index and ends the frame
   a_check_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_check) |->
         (rsp_last && rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0))
      else $error("malformed check result");

   // a data result never carries a verdict
   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_check) |-> (!rsp_last && !rsp_crc_ok))
      else $error("malformed data result");

endmodule

`default_nettype wire

// ----- hw/rtl/cfc_csr_regs.sv -----
// cfc_csr_regs: address, command and length registers behind the write port
// depends on cfc_pkg
`default_nettype none

module cfc_csr_regs (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [cfc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [7:0]                     csr_wdata,
   output cfc_pkg::cfg_type                    cfg
);
   import cfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS:  cfg_in.device_address  = csr_wdata;
            CSR_COMMAND_CODE:    cfg_in.command_code    = csr_wdata;
            CSR_RESPONSE_LENGTH: cfg_in.response_length = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address  <= RST_DEVICE_ADDRESS;
         cfg_ff.command_code    <= RST_COMMAND_CODE;
         cfg_ff.response_length <= RST_RESPONSE_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cfc_frame_engine.sv -----
// cfc_frame_engine: frame state and per-byte crc step, one byte per enable
// depends on cfc_pkg
`default_nettype none

module cfc_frame_engine (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cfc_pkg::cfg_type cfg,
   input  wire logic           step_en,
   input  wire logic [7:0]     byte_value,
   input  wire logic           start_req,
   output logic                has_result,
   output cfc_pkg::result_type result
);
   import cfc_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  crc_high_ff, crc_high_in;
   logic        active_ff, active_in;

   logic        new_frame;
   logic [15:0] crc_base;
   logic [8:0]  pos_base;
   logic [7:0]  high_base;
   logic [8:0]  len_ext;

   always_comb begin
      new_frame = start_req || !active_ff;
      crc_base  = new_frame ? crc_fold(crc_fold(16'h0000, cfg.device_address),
                                       cfg.command_code) : crc_ff;
      pos_base  = new_frame ? 9'd0 : pos_ff;
      high_base = new_frame ? 8'd0 : crc_high_ff;
      len_ext   = {1'b0, cfg.response_length};

      crc_in      = crc_base;
      pos_in      = pos_base;
      crc_high_in = high_base;
      active_in   = 1'b1;
      has_result  = 1'b0;
      result      = '0;

      if (pos_base < len_ext) begin
         crc_in            = crc_fold(crc_base, byte_value);
         pos_in            = pos_base + 9'd1;
         has_result        = 1'b1;
         result.data_byte  = byte_value;
         result.byte_index = pos_base[7:0];
      end else if (pos_base == len_ext) begin
         crc_high_in = byte_value;
         pos_in      = pos_base + 9'd1;
      end else begin
         has_result      = 1'b1;
         result.is_check = 1'b1;
         result.last     = 1'b1;
         result.crc_ok   = ({high_base, byte_value} == crc_base);
         active_in       = 1'b0;
         pos_in          = 9'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= '0;
         pos_ff      <= '0;
         crc_high_ff <= '0;
         active_ff   <= 1'b0;
      end else if (step_en) begin
         crc_ff      <= crc_in;
         pos_ff      <= pos_in;
         crc_high_ff <= crc_high_in;
         active_ff   <= active_in;
      end
   end

endmodule

`default_nettype wire
